[rtl/bcts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcts_pkg: shared types and codes of the battery cell test sequencer
// Phase codes, request codes, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package bcts_pkg;

   // test phases, as reported on the result channel
   typedef enum logic [2:0] {
      PH_STANDBY   = 3'd0,
      PH_IDLE      = 3'd1,
      PH_PRECHARGE = 3'd2,
      PH_DISCHARGE = 3'd3,
      PH_CHARGE    = 3'd4,
      PH_REST      = 3'd5,
      PH_DS_RES    = 3'd6,
      PH_CS_RES    = 3'd7
   } phase_type;

   // sequencer of one request beat
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EVAL,
      SEQ_MUL,
      SEQ_DIV,
      SEQ_OUT
   } seq_state_type;

   // request codes
   localparam logic [1:0] REQ_PERIOD = 2'd0;
   localparam logic [1:0] REQ_START  = 2'd1;
   localparam logic [1:0] REQ_ABORT  = 2'd2;

   // test sequences
   localparam logic [1:0] TSEQ_FULL      = 2'd0;
   localparam logic [1:0] TSEQ_DIS_CHG   = 2'd1;
   localparam logic [1:0] TSEQ_CHG_ONLY  = 2'd2;
   localparam logic [1:0] TSEQ_DIS_ONLY  = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_TEST_SEQUENCE  = 3'd0;
   localparam logic [2:0] CSR_CELL_TOTAL     = 3'd1;
   localparam logic [2:0] CSR_END_CHARGE_MA  = 3'd2;
   localparam logic [2:0] CSR_END_DISCH_MV   = 3'd3;
   localparam logic [2:0] CSR_CONFIRM        = 3'd4;
   localparam logic [2:0] CSR_REST           = 3'd5;
   localparam logic [2:0] CSR_RES_PERIODS    = 3'd6;

   // fixed constants
   localparam logic [15:0] LOW_CELL_MV    = 16'd900;
   localparam logic [13:0] RES_SCALE      = 14'd10000;
   localparam logic [23:0] RES_MAX        = 24'hFF_FFFF;
   localparam logic [7:0]  RES_SAMPLE_CNT = 8'd4;
   localparam logic [7:0]  RES_RESULT_CNT = 8'd1;

   // per-beat status flags of one result
   typedef struct packed {
      logic fault;
      logic cell_done;
      logic all_done;
      logic res_valid;
      logic res_error;
   } rsp_flags_type;

endpackage
`default_nettype wire

[rtl/battery_cell_test_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_cell_test_sequencer: multi-cell charge/discharge test sequencer
// Steps cells through precharge, discharge, charge, rest and DC-resistance
// phases, one step per request beat, and reports the state after each beat.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  -------  ---------  ------------------  ----------------------------------
//  req      in         req_valid/req_stall  type, voltage_mv, current_ma
//  rsp      out        rsp_valid/rsp_stall  phase, converter, cell, flags, R
//  csr      in         csr_valid/csr_ready  3-bit index, 16-bit data
//
//  A beat goes from acceptance through evaluation to the output step. The beat
//  that closes a resistance measurement with positive differences also passes
//  through a multiply by 10000 and then a shift-subtract divider that yields
//  one quotient bit per cycle.
//  Reset clears the sequencer, the test state and the registers to defaults.
//  req_stall stays high from acceptance until the result is loaded into the
//  output register; a stalled result holds while the next beat is worked on.
//  csr_ready is always high; write registers only while the block is idle.
//
module battery_cell_test_sequencer
   import bcts_pkg::*;
#(
   parameter int MAX_CELLS = 4,
   parameter int MEAS_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [15:0] req_voltage_mv,
   input  wire logic [15:0] req_current_ma,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_phase,
   output logic             rsp_converter_on,
   output logic [1:0]       rsp_current_setting,
   output logic [2:0]       rsp_cell_number,
   output logic             rsp_low_cell_fault,
   output logic             rsp_cell_finished,
   output logic             rsp_all_finished,
   output logic [23:0]      rsp_resistance_value,
   output logic             rsp_resistance_valid,
   output logic             rsp_resistance_error,
   // configuration channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   // measurement width after masking, and divider widths
   localparam int MW = (MEAS_BITS < 16) ? MEAS_BITS : 16;
   localparam int DW = MW + 14;
   localparam int CW = $clog2(DW);
   localparam logic [3:0] MaxCells = 4'(MAX_CELLS);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [1:0]  test_seq_ff;
   logic [2:0]  cell_total_ff;
   logic [15:0] end_chg_ma_ff;
   logic [15:0] end_dis_mv_ff;
   logic [15:0] confirm_periods_ff;
   logic [15:0] rest_periods_ff;
   logic [7:0]  res_periods_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         test_seq_ff        <= TSEQ_FULL;
         cell_total_ff      <= 3'd1;
         end_chg_ma_ff      <= 16'd100;
         end_dis_mv_ff      <= 16'd3000;
         confirm_periods_ff <= 16'd0;
         rest_periods_ff    <= 16'd10;
         res_periods_ff     <= 8'd15;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TEST_SEQUENCE: test_seq_ff        <= csr_data[1:0];
            CSR_CELL_TOTAL:    cell_total_ff      <= csr_data[2:0];
            CSR_END_CHARGE_MA: end_chg_ma_ff      <= csr_data;
            CSR_END_DISCH_MV:  end_dis_mv_ff      <= csr_data;
            CSR_CONFIRM:       confirm_periods_ff <= csr_data;
            CSR_REST:          rest_periods_ff    <= csr_data;
            CSR_RES_PERIODS:   res_periods_ff     <= csr_data[7:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   seq_state_type state_ff, state_in;
   logic [CW-1:0] div_cnt_ff;
   logic          div_go;
   logic          out_free;

   // output register is free when empty or being taken this cycle
   assign out_free = !rsp_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) state_in = SEQ_EVAL;
         end
         SEQ_EVAL: state_in = div_go ? SEQ_MUL : SEQ_OUT;
         SEQ_MUL:  state_in = SEQ_DIV;
         SEQ_DIV: begin
            if (div_cnt_ff == CW'(DW - 1)) state_in = SEQ_OUT;
         end
         SEQ_OUT: begin
            if (out_free) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // captured request beat
   // ---------------------------------------------------------------------
   logic [1:0]    req_type_ff;
   logic [MW-1:0] volt_ff;
   logic [MW-1:0] curr_ff;

   always_ff @(posedge clock) begin
      if (state_ff == SEQ_IDLE && req_valid) begin
         req_type_ff <= req_type;
         volt_ff     <= req_voltage_mv[MW-1:0];
         curr_ff     <= req_current_ma[MW-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // test state and one step of the phase machine
   // ---------------------------------------------------------------------
   phase_type     phase_ff, phase_in;
   phase_type     pbr_ff, pbr_in;
   logic [2:0]    cell_ff, cell_in;
   logic [15:0]   confirm_ff, confirm_in;
   logic [15:0]   rest_ff, rest_in;
   logic [7:0]    rcnt_ff, rcnt_in;
   logic [MW-1:0] first_v_ff, first_v_in;
   logic [MW-1:0] first_i_ff, first_i_in;
   rsp_flags_type flags_ff, flags_in;
   logic [MW-1:0] vdiff_ff, vdiff_in;
   logic [MW-1:0] idiff_ff, idiff_in;

   // step actions, at most one per beat
   logic          go_work, go_res, go_rest, go_finish;
   phase_type     work_phase, res_phase, rest_from, begin_phase;
   logic [3:0]    total;
   logic [15:0]   volt16, curr16;

   assign volt16 = 16'(volt_ff);
   assign curr16 = 16'(curr_ff);

   always_comb begin
      case (test_seq_ff)
         TSEQ_FULL:     begin_phase = PH_PRECHARGE;
         TSEQ_CHG_ONLY: begin_phase = PH_CHARGE;
         default:       begin_phase = PH_DISCHARGE;
      endcase
   end

   // effective cell count: clamp to 1..MAX_CELLS
   always_comb begin
      total = {1'b0, cell_total_ff};
      if (total == 4'd0) total = 4'd1;
      if (total > MaxCells) total = MaxCells;
   end

   always_comb begin
      phase_in   = phase_ff;
      pbr_in     = pbr_ff;
      cell_in    = cell_ff;
      confirm_in = confirm_ff;
      rest_in    = rest_ff;
      rcnt_in    = rcnt_ff;
      first_v_in = first_v_ff;
      first_i_in = first_i_ff;
      vdiff_in   = first_v_ff - volt_ff;
      idiff_in   = curr_ff - first_i_ff;
      flags_in   = '0;
      div_go     = 1'b0;
      go_work    = 1'b0;
      go_res     = 1'b0;
      go_rest    = 1'b0;
      go_finish  = 1'b0;
      work_phase = begin_phase;
      res_phase  = PH_DS_RES;
      rest_from  = phase_ff;

      case (req_type_ff)
         REQ_ABORT: phase_in = PH_STANDBY;
         REQ_START: begin
            if (phase_ff == PH_STANDBY) begin
               cell_in = 3'd1;
               go_work = 1'b1;
            end else if (phase_ff == PH_IDLE) begin
               go_work = 1'b1;
            end
         end
         REQ_PERIOD: begin
            unique case (phase_ff)
               PH_IDLE: go_work = 1'b1;
               PH_PRECHARGE: begin
                  if (volt16 < LOW_CELL_MV) begin
                     phase_in       = PH_STANDBY;
                     flags_in.fault = 1'b1;
                  end else if (curr16 < end_chg_ma_ff) begin
                     if (confirm_ff == 16'd0) go_rest = 1'b1;
                     else confirm_in = confirm_ff - 16'd1;
                  end
               end
               PH_DISCHARGE: begin
                  if (volt16 < end_dis_mv_ff) begin
                     if (test_seq_ff == TSEQ_DIS_ONLY) go_finish = 1'b1;
                     else if (confirm_ff == 16'd0) go_rest = 1'b1;
                     else confirm_in = confirm_ff - 16'd1;
                  end
               end
               PH_CHARGE: begin
                  if (volt16 < LOW_CELL_MV) begin
                     phase_in       = PH_STANDBY;
                     flags_in.fault = 1'b1;
                  end else if (curr16 < end_chg_ma_ff) begin
                     if (test_seq_ff == TSEQ_CHG_ONLY || test_seq_ff == TSEQ_DIS_ONLY) begin
                        go_finish = 1'b1;
                     end else if (confirm_ff == 16'd0) begin
                        go_rest = 1'b1;
                     end else begin
                        confirm_in = confirm_ff - 16'd1;
                     end
                  end
               end
               PH_REST: begin
                  if (rest_ff != 16'd0) begin
                     rest_in = rest_ff - 16'd1;
                  end else begin
                     case (pbr_ff)
                        PH_PRECHARGE: begin
                           go_work    = 1'b1;
                           work_phase = PH_DISCHARGE;
                        end
                        PH_DISCHARGE: go_res = 1'b1;
                        PH_CHARGE: begin
                           go_res    = 1'b1;
                           res_phase = PH_CS_RES;
                        end
                        PH_DS_RES: begin
                           go_work    = 1'b1;
                           work_phase = PH_CHARGE;
                        end
                        default: go_finish = 1'b1;
                     endcase
                  end
               end
               PH_DS_RES, PH_CS_RES: begin
                  if (rcnt_ff == RES_SAMPLE_CNT) begin
                     first_v_in = volt_ff;
                     first_i_in = curr_ff;
                  end
                  if (rcnt_ff == RES_RESULT_CNT) begin
                     if (first_v_ff > volt_ff && curr_ff > first_i_ff) begin
                        div_go             = 1'b1;
                        flags_in.res_valid = 1'b1;
                     end else begin
                        flags_in.res_error = 1'b1;
                     end
                  end
                  if (rcnt_ff == 8'd0) go_rest = 1'b1;
                  else rcnt_in = rcnt_ff - 8'd1;
               end
               default: ;  // standby ignores periods
            endcase
         end
         default: ;  // unknown request: report state only
      endcase

      // apply the phase entry of this step
      if (go_work) begin
         phase_in   = work_phase;
         confirm_in = confirm_periods_ff;
      end
      if (go_res) begin
         phase_in = res_phase;
         rcnt_in  = res_periods_ff;
      end
      if (go_rest) begin
         phase_in = PH_REST;
         pbr_in   = rest_from;
         rest_in  = rest_periods_ff;
      end
      if (go_finish) begin
         flags_in.cell_done = 1'b1;
         if ({1'b0, cell_ff} < total) begin
            cell_in  = cell_ff + 3'd1;
            phase_in = PH_IDLE;
         end else begin
            phase_in          = PH_STANDBY;
            flags_in.all_done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_STANDBY;
         pbr_ff     <= PH_STANDBY;
         cell_ff    <= 3'd1;
         confirm_ff <= 16'd0;
         rest_ff    <= 16'd0;
         rcnt_ff    <= 8'd0;
         first_v_ff <= '0;
         first_i_ff <= '0;
      end else if (state_ff == SEQ_EVAL) begin
         phase_ff   <= phase_in;
         pbr_ff     <= pbr_in;
         cell_ff    <= cell_in;
         confirm_ff <= confirm_in;
         rest_ff    <= rest_in;
         rcnt_ff    <= rcnt_in;
         first_v_ff <= first_v_in;
         first_i_ff <= first_i_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == SEQ_EVAL) begin
         flags_ff <= flags_in;
         vdiff_ff <= vdiff_in;
         idiff_ff <= idiff_in;
      end
   end

   // ---------------------------------------------------------------------
   // resistance: multiply by 10000, then shift-subtract divide
   // ---------------------------------------------------------------------
   logic [DW-1:0] quot_ff;
   logic [MW-1:0] rem_ff;
   logic [23:0]   res_ff;
   logic [DW-1:0] mul_prod;
   logic [MW:0]   rem_sh;
   logic [MW:0]   rem_diff;
   logic          rem_ge;
   logic [DW-1:0] quot_next;

   assign mul_prod  = DW'(vdiff_ff) * DW'(RES_SCALE);
   assign rem_sh    = {rem_ff, quot_ff[DW-1]};
   assign rem_ge    = rem_sh >= {1'b0, idiff_ff};
   assign rem_diff  = rem_sh - {1'b0, idiff_ff};
   assign quot_next = {quot_ff[DW-2:0], rem_ge};

   always_ff @(posedge clock) begin
      if (state_ff == SEQ_MUL) begin
         quot_ff    <= mul_prod;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (state_ff == SEQ_DIV) begin
         // bring down one dividend bit, subtract when it fits
         quot_ff    <= quot_next;
         rem_ff     <= rem_ge ? rem_diff[MW-1:0] : rem_sh[MW-1:0];
         div_cnt_ff <= div_cnt_ff + CW'(1);
         // saturate the finished quotient to 24 bits
         if (div_cnt_ff == CW'(DW - 1)) begin
            res_ff <= (quot_next > DW'(RES_MAX)) ? RES_MAX : quot_next[23:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   logic conv_now;
   logic [1:0] setting_now;

   // converter drive follows the phase just entered
   always_comb begin
      conv_now    = 1'b0;
      setting_now = 2'd0;
      case (phase_ff)
         PH_PRECHARGE, PH_CHARGE: conv_now = 1'b1;
         PH_DISCHARGE: begin
            conv_now    = 1'b1;
            setting_now = 2'd1;
         end
         PH_DS_RES, PH_CS_RES: begin
            if (rcnt_ff != 8'd0) begin
               conv_now    = 1'b1;
               setting_now = (rcnt_ff < RES_SAMPLE_CNT) ? 2'd3 : 2'd2;
            end
         end
         default: ;
      endcase
   end

   logic load_out;
   assign load_out = (state_ff == SEQ_OUT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (load_out) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_phase            <= phase_ff;
         rsp_converter_on     <= conv_now;
         rsp_current_setting  <= setting_now;
         rsp_cell_number      <= cell_ff;
         rsp_low_cell_fault   <= flags_ff.fault;
         rsp_cell_finished    <= flags_ff.cell_done;
         rsp_all_finished     <= flags_ff.all_done;
         rsp_resistance_value <= flags_ff.res_valid ? res_ff : 24'd0;
         rsp_resistance_valid <= flags_ff.res_valid;
         rsp_resistance_error <= flags_ff.res_error;
      end
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == SEQ_OUT))
      else $error("result raised outside the output step");

   a_res_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_resistance_valid && rsp_resistance_error))
      else $error("resistance valid and error together");

   a_res_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_resistance_valid) |-> (rsp_resistance_value == 24'd0))
      else $error("resistance value without a fresh result");

   a_conv_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_converter_on) |-> (rsp_current_setting == 2'd0))
      else $error("current setting with converter off");

   a_all_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_all_finished) |-> (rsp_cell_finished && rsp_phase == PH_STANDBY))
      else $error("all finished without cell finished in standby");

endmodule
`default_nettype wire
